### sv/ist_pkg.sv
// ============================================================================
// ist_pkg - integer set table shared definitions
// Request/result types, command codes and sequencer phases.
// ============================================================================
`default_nettype none

package ist_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 2;
    localparam int RSP_COUNT_W  = 5;

    // command codes; code 3 is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TEST = 2'd2
    } ist_cmd_e;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMP,
        PH_UPD
    } ist_phase_e;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
    } ist_req_t;

    typedef struct packed {
        logic                   hit;
        logic                   full_refused;
        logic [RSP_COUNT_W-1:0] entry_count;
    } ist_rsp_t;

    // broadcast from sequencer to every cell
    typedef struct packed {
        logic               cmp;     // latch compare result this cycle
        logic               add_en;  // first empty cell takes the value
        logic               del_en;  // cells at/after the match pull from neighbor
        logic [VALUE_W-1:0] value;
    } ist_ctrl_t;

endpackage

`default_nettype wire

### sv/ist_cell.sv
// ============================================================================
// ist_cell - one slot of the set table
// Holds a value and valid bit, compares against the request, shifts down.
// ============================================================================
`default_nettype none

module ist_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ist_pkg::ist_ctrl_t          ctrl,
    input  wire logic                        prev_valid,  // tie 1 for slot 0
    input  wire logic [ist_pkg::VALUE_W-1:0] next_value,
    input  wire logic                        next_valid,  // tie 0 for last slot
    input  wire logic                        match_in,    // match seen below
    output logic [ist_pkg::VALUE_W-1:0]      value,
    output logic                             valid,
    output logic                             match_out
);
    import ist_pkg::*;

    logic [VALUE_W-1:0] value_reg, value_next;
    logic               valid_reg, valid_next;
    logic               match_reg, match_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.cmp)
        begin
            match_next = valid_reg && (value_reg == ctrl.value);
        end
        if (ctrl.add_en && !valid_reg && prev_valid)
        begin
            value_next = ctrl.value;
            valid_next = 1'b1;
        end
        else if (ctrl.del_en && match_out)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign valid     = valid_reg;
    assign match_out = match_in | match_reg;

endmodule

`default_nettype wire

### sv/integer_set_table.sv
// ============================================================================
// integer_set_table - bounded set of distinct signed 32-bit integers
// Add / delete / test requests over a row of compare-and-shift cells.
// ============================================================================
// done rises after the compare and update phases, when the result is taken from
//   the output reg.
// A new request can be taken in the update cycle; busy is high during the compare cycle,
//   since the following request must compare against the updated row.
// The receiver cannot stall: each result sits on rsp for the single cycle done is high.
// Reset (rst_n, async, active low) empties the set; no clearing pass is needed.
`default_nettype none

module integer_set_table #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ist_pkg::ist_req_t req,
    output logic                   done,
    output ist_pkg::ist_rsp_t      rsp
);
    import ist_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    ist_phase_e          phase_reg, phase_next;
    ist_req_t            req_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    ist_rsp_t            rsp_reg, rsp_next;
    logic                done_reg, done_next;
    logic                accept;

    // cell row wiring
    ist_ctrl_t           ctrl;
    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY:0]   match_chain;  // running OR of matches, slot 0 upward

    logic                any_match;
    logic                is_full;
    logic                upd;
    logic                cmd_add, cmd_del, cmd_test;
    logic [COUNT_W+RSP_COUNT_W-1:0] count_wide;

    assign accept         = start && !busy;
    assign busy           = (phase_reg == PH_CMP);
    assign match_chain[0] = 1'b0;
    assign any_match      = match_chain[CAPACITY];
    assign is_full        = (count_reg == COUNT_W'(CAPACITY));
    assign upd            = (phase_reg == PH_UPD);
    assign cmd_add        = (req_reg.cmd == CMD_ADD);
    assign cmd_del        = (req_reg.cmd == CMD_DEL);
    assign cmd_test       = (req_reg.cmd == CMD_TEST);

    always_comb
    begin
        ctrl.cmp    = (phase_reg == PH_CMP);
        ctrl.add_en = upd && cmd_add && !any_match && !is_full;
        ctrl.del_en = upd && cmd_del && any_match;
        ctrl.value  = req_reg.value;
    end

    // ------------------------------------------------------------------
    // Cell row: slot k pulls from slot k+1 on delete; valid slots stay
    // packed at the low end, so the first empty slot is the append point.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic               prev_v;
        logic [VALUE_W-1:0] nxt_value;
        logic               nxt_valid;

        if (k == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = cell_valid[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign nxt_value = ctrl.value;  // don't care, valid goes to 0
            assign nxt_valid = 1'b0;
        end
        else
        begin : g_inner
            assign nxt_value = cell_value[k+1];
            assign nxt_valid = cell_valid[k+1];
        end

        ist_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .next_value (nxt_value),
            .next_valid (nxt_valid),
            .match_in   (match_chain[k]),
            .value      (cell_value[k]),
            .valid      (cell_valid[k]),
            .match_out  (match_chain[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer: accept -> compare -> update; a new request may be taken
    // in the update cycle since its compare follows the update.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: phase_next = accept ? PH_CMP : PH_IDLE;
            PH_CMP:  phase_next = PH_UPD;
            PH_UPD:  phase_next = accept ? PH_CMP : PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.add_en)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctrl.del_en)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
        count_wide = {{RSP_COUNT_W{1'b0}}, count_next};

        done_next             = upd;
        rsp_next.hit          = ctrl.add_en || ctrl.del_en || (cmd_test && any_match);
        rsp_next.full_refused = cmd_add && !any_match && is_full;
        rsp_next.entry_count  = count_wide[RSP_COUNT_W-1:0];  // reported mod 32
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            if (upd)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (upd)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(phase_reg == PH_UPD))
        else $error("done without a preceding update cycle");

    a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("entry count disagrees with valid cells");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("entry count above capacity");

    a_refused_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.full_refused) |-> !rsp.hit)
        else $error("refused add also reports hit");

endmodule

`default_nettype wire
